// ===== rtl/discovery_tlv_address_collector_macros.svh =====
// assertion macros shared by the address collector rtl
`ifndef DISCOVERY_TLV_ADDRESS_COLLECTOR_MACROS_SVH
`define DISCOVERY_TLV_ADDRESS_COLLECTOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define DTAC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define DTAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/dtac_pkg.sv =====
// types and constants of the address collector
`default_nettype none

package dtac_pkg;

    localparam int unsigned CAP_BYTES = 10;
    localparam int unsigned VIDX_W    = 4;

    localparam logic [7:0]  VER_1        = 8'd1;
    localparam logic [7:0]  VER_2        = 8'd2;
    localparam logic [7:0]  CMD_0        = 8'd0;
    localparam logic [7:0]  REC_TYPE_RST = 8'd2;
    localparam logic [15:0] MIN_BUF      = 16'd4;
    localparam logic [16:0] HDR_BYTES    = 17'd4;
    localparam logic [15:0] HDR_LAST_POS = 16'd3;
    localparam logic [VIDX_W-1:0] CAP_FULL = VIDX_W'(CAP_BYTES);

    localparam logic KIND_ADDR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_LEN_OVER    = 3'd1,
        ST_EMPTY_V1    = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_SHORT_BUF   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_TYPE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_VALUE
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_SEARCH,
        SQ_ADDR,
        SQ_STATUS
    } t_seq;

    typedef struct packed {
        logic start;
        logic clear;
    } t_tbl_ctl;

    typedef struct packed {
        logic busy;
        logic added;
    } t_tbl_sts;

endpackage

`default_nettype wire

// ===== rtl/dtac_table.sv =====
// address table with one-entry-per-cycle duplicate search and append
`default_nettype none

`include "discovery_tlv_address_collector_macros.svh"

module dtac_table
    import dtac_pkg::*;
#(
    parameter int unsigned KEY_W   = 48,
    parameter int unsigned ENTRIES = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_tbl_ctl         i_ctl,
    input  wire logic [KEY_W-1:0] i_key,
    output t_tbl_sts              o_sts
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    logic [KEY_W-1:0] r_mem [ENTRIES];
    logic [KEY_W-1:0] r_rd_data;
    logic [KEY_W-1:0] r_key;
    logic [IW-1:0]    r_idx;
    logic [CW-1:0]    r_count;
    logic             r_busy;
    logic             r_issue;
    logic             r_cmp_vld;
    logic             r_hit;
    logic             r_added;
    logic             w_finish;
    logic             w_insert;

    assign w_finish = r_busy && !r_issue && !r_cmp_vld;
    assign w_insert = !r_hit && (r_count < CW'(ENTRIES));

    always_ff @(posedge i_clk) begin
        if (r_busy && r_issue) begin
            r_rd_data <= r_mem[r_idx];
        end
        if (w_finish && w_insert) begin
            r_mem[r_count[IW-1:0]] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_issue   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_added   <= 1'b0;
            r_idx     <= '0;
            r_count   <= '0;
        end else begin
            if (i_ctl.clear) begin
                r_count <= '0;
            end
            if (i_ctl.start) begin
                r_busy    <= 1'b1;
                r_key     <= i_key;
                r_hit     <= 1'b0;
                r_idx     <= '0;
                r_issue   <= (r_count != '0);
                r_cmp_vld <= 1'b0;
            end else if (r_busy) begin
                r_cmp_vld <= r_issue;
                if (r_issue) begin
                    if ((CW'(r_idx) + CW'(1)) == r_count) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                if (r_cmp_vld && (r_rd_data == r_key)) begin
                    r_hit <= 1'b1;
                end
                if (w_finish) begin
                    r_busy  <= 1'b0;
                    r_added <= w_insert;
                    if (w_insert) begin
                        r_count <= r_count + CW'(1);
                    end
                end
            end
        end
    end

    assign o_sts.busy  = r_busy;
    assign o_sts.added = r_added;

    `DTAC_ASSERT_NEXT(a_finish_ends_search, w_finish && !i_ctl.start, !r_busy)
    `DTAC_ASSERT_IMPL(a_count_in_range, 1'b1, r_count <= CW'(ENTRIES))
    `DTAC_ASSERT_IMPL(a_issue_only_busy, r_issue || r_cmp_vld, r_busy)

endmodule

`default_nettype wire

// ===== rtl/discovery_tlv_address_collector.sv =====
// discovery packet parser that collects mac and ipv4 addresses from tlv records
//
// usage: packet bytes enter on the input channel (i_in_valid / o_in_stall),
// one byte per transfer, i_first_byte and i_buffer_length marking a new buffer.
// results leave on the output channel (o_out_valid / i_out_stall): address
// records with their table-insert flags and one end-of-packet status per packet.
// the record type code is written through i_cfg_valid / o_cfg_ready / i_cfg_data.
// a byte that makes no address result leaves the sequencer idle; its status
// result, if any, sits in the output register the next cycle. a byte that
// completes an address record starts a search of both tables, one entry per
// cycle through a registered memory read. the address result is loaded once
// both searches end and the output register is free, and the next byte is
// taken after it, or after the status result that follows it at packet end.
// o_in_stall is high while the sequencer is busy or the output register holds a
// result that the receiver does not take in the same cycle; a stalled result
// holds its value. reset clears the parser, empties both tables and sets the
// record type to 2.
`default_nettype none

`include "discovery_tlv_address_collector_macros.svh"

module discovery_tlv_address_collector
    import dtac_pkg::*;
#(
    parameter int unsigned MAC_ENTRIES = 10,
    parameter int unsigned IP_ENTRIES  = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first_byte,
    input  wire logic [15:0] i_buffer_length,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_kind,
    output logic [47:0]      o_mac,
    output logic [31:0]      o_ipv4,
    output logic             o_mac_added,
    output logic             o_ip_added,
    output logic [2:0]       o_status,
    output logic             o_last
);

    logic [7:0]        r_rec_type;
    t_phase            r_phase, n_phase;
    logic [15:0]       r_pos, n_pos;
    logic [15:0]       r_size, n_size;
    logic [23:0]       r_hdr, n_hdr;
    logic [7:0]        r_rtype, n_rtype;
    logic [15:0]       r_remain, n_remain;
    logic [VIDX_W-1:0] r_vidx, n_vidx;
    logic [7:0]        r_cap [CAP_BYTES];
    logic [7:0]        n_cap [CAP_BYTES];

    t_seq              r_seq, n_seq;
    logic              r_end_pending;
    logic [47:0]       r_addr_mac;
    logic [31:0]       r_addr_ip;

    logic              r_out_valid;
    logic              r_kind;
    logic [47:0]       r_mac;
    logic [31:0]       r_ip;
    logic              r_mac_added;
    logic              r_ip_added;
    t_status           r_status;
    logic              r_last;

    logic              w_in_acc;
    logic              w_out_free;
    logic              w_stat;
    t_status           w_code;
    logic              w_end;
    logic              w_addr;
    logic              w_done;
    logic              w_clear;
    logic              w_start;
    logic              w_ld_status;
    logic              w_ld_addr;
    t_status           w_ld_code;
    logic [15:0]       w_hdr_len;
    logic [23:0]       w_hdr_old;
    logic [47:0]       w_mac_key;
    logic [31:0]       w_ip_key;
    t_tbl_ctl          w_tbl_ctl;
    t_tbl_sts          w_mac_sts;
    t_tbl_sts          w_ip_sts;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_seq == SQ_IDLE) && w_out_free);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_hdr_old = i_first_byte ? 24'd0 : r_hdr;
    assign w_hdr_len = {w_hdr_old[7:0], i_data_byte};

    // per-byte parser step
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_size   = r_size;
        n_hdr    = r_hdr;
        n_rtype  = r_rtype;
        n_remain = r_remain;
        n_vidx   = r_vidx;
        n_cap    = r_cap;
        w_clear  = 1'b0;
        w_stat   = 1'b0;
        w_code   = ST_OK;
        w_end    = 1'b0;
        w_addr   = 1'b0;
        w_done   = 1'b0;
        if (w_in_acc) begin
            if (i_first_byte) begin
                w_clear = 1'b1;
                n_size  = i_buffer_length;
                n_pos   = 16'd0;
                n_hdr   = 24'd0;
                n_phase = PH_HEADER;
            end
            if (i_first_byte && (i_buffer_length < MIN_BUF)) begin
                n_phase = PH_IDLE;
                w_stat  = 1'b1;
                w_code  = ST_SHORT_BUF;
            end else if (n_phase != PH_IDLE) begin
                unique case (n_phase)
                    PH_HEADER: begin
                        n_hdr = {w_hdr_old[15:0], i_data_byte};
                        if (n_pos == HDR_LAST_POS) begin
                            priority if (({1'b0, w_hdr_len} + HDR_BYTES) > {1'b0, n_size}) begin
                                n_phase = PH_IDLE;
                                w_stat  = 1'b1;
                                w_code  = ST_LEN_OVER;
                                w_done  = 1'b1;
                            end else if ((w_hdr_old[23:16] == VER_1)
                                         && (w_hdr_old[15:8] == CMD_0)) begin
                                n_phase = PH_IDLE;
                                w_stat  = 1'b1;
                                w_code  = (w_hdr_len == 16'd0) ? ST_EMPTY_V1 : ST_OK;
                                w_done  = 1'b1;
                            end else if (w_hdr_old[23:16] != VER_2) begin
                                n_phase = PH_IDLE;
                                w_stat  = 1'b1;
                                w_code  = ST_BAD_VERSION;
                                w_done  = 1'b1;
                            end else begin
                                n_phase = PH_TYPE;
                            end
                        end
                    end
                    PH_TYPE: begin
                        n_rtype = i_data_byte;
                        n_phase = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        n_remain = {i_data_byte, 8'd0};
                        n_phase  = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_remain = {r_remain[15:8], i_data_byte};
                        n_vidx   = '0;
                        n_phase  = (n_remain == 16'd0) ? PH_TYPE : PH_VALUE;
                    end
                    PH_VALUE: begin
                        if (r_vidx < CAP_FULL) begin
                            n_cap[r_vidx] = i_data_byte;
                            n_vidx        = r_vidx + VIDX_W'(1);
                        end
                        n_remain = r_remain - 16'd1;
                        if (n_remain == 16'd0) begin
                            n_phase = PH_TYPE;
                            if ((r_rtype == r_rec_type) && (n_vidx == CAP_FULL)) begin
                                w_addr = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                if (!w_done) begin
                    if (({1'b0, n_pos} + 17'd1) >= {1'b0, n_size}) begin
                        n_phase = PH_IDLE;
                        w_end   = 1'b1;
                    end
                    n_pos = n_pos + 16'd1;
                end
            end
        end
    end

    assign w_mac_key = {n_cap[0], n_cap[1], n_cap[2], n_cap[3], n_cap[4], n_cap[5]};
    assign w_ip_key  = {n_cap[6], n_cap[7], n_cap[8], n_cap[9]};

    // sequencer
    always_comb begin
        n_seq       = r_seq;
        w_start     = 1'b0;
        w_ld_status = 1'b0;
        w_ld_addr   = 1'b0;
        w_ld_code   = ST_OK;
        unique case (r_seq)
            SQ_IDLE: begin
                if (w_in_acc) begin
                    if (w_addr) begin
                        n_seq   = SQ_SEARCH;
                        w_start = 1'b1;
                    end else if (w_stat || w_end) begin
                        w_ld_status = 1'b1;
                        w_ld_code   = w_stat ? w_code : ST_OK;
                    end
                end
            end
            SQ_SEARCH: begin
                if (!w_mac_sts.busy && !w_ip_sts.busy) begin
                    n_seq = SQ_ADDR;
                end
            end
            SQ_ADDR: begin
                if (w_out_free) begin
                    w_ld_addr = 1'b1;
                    n_seq     = r_end_pending ? SQ_STATUS : SQ_IDLE;
                end
            end
            SQ_STATUS: begin
                if (w_out_free) begin
                    w_ld_status = 1'b1;
                    n_seq       = SQ_IDLE;
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    assign w_tbl_ctl.start = w_start;
    assign w_tbl_ctl.clear = w_clear;

    dtac_table #(
        .KEY_W   (48),
        .ENTRIES (MAC_ENTRIES)
    ) u_mac_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_tbl_ctl),
        .i_key   (w_mac_key),
        .o_sts   (w_mac_sts)
    );

    dtac_table #(
        .KEY_W   (32),
        .ENTRIES (IP_ENTRIES)
    ) u_ip_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_tbl_ctl),
        .i_key   (w_ip_key),
        .o_sts   (w_ip_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_type    <= REC_TYPE_RST;
            r_phase       <= PH_IDLE;
            r_pos         <= 16'd0;
            r_size        <= 16'd0;
            r_hdr         <= 24'd0;
            r_rtype       <= 8'd0;
            r_remain      <= 16'd0;
            r_vidx        <= '0;
            r_seq         <= SQ_IDLE;
            r_end_pending <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_rec_type <= i_cfg_data;
            end
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_size   <= n_size;
            r_hdr    <= n_hdr;
            r_rtype  <= n_rtype;
            r_remain <= n_remain;
            r_vidx   <= n_vidx;
            r_seq    <= n_seq;
            if (w_start) begin
                r_end_pending <= w_end;
            end
            if (w_ld_status || w_ld_addr) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap <= n_cap;
        if (w_start) begin
            r_addr_mac <= w_mac_key;
            r_addr_ip  <= w_ip_key;
        end
        if (w_ld_status) begin
            r_kind      <= KIND_STATUS;
            r_mac       <= 48'd0;
            r_ip        <= 32'd0;
            r_mac_added <= 1'b0;
            r_ip_added  <= 1'b0;
            r_status    <= w_ld_code;
            r_last      <= 1'b1;
        end else if (w_ld_addr) begin
            r_kind      <= KIND_ADDR;
            r_mac       <= r_addr_mac;
            r_ip        <= r_addr_ip;
            r_mac_added <= w_mac_sts.added;
            r_ip_added  <= w_ip_sts.added;
            r_status    <= ST_OK;
            r_last      <= !r_end_pending;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_mac       = r_mac;
    assign o_ipv4      = r_ip;
    assign o_mac_added = r_mac_added;
    assign o_ip_added  = r_ip_added;
    assign o_status    = r_status;
    assign o_last      = r_last;

    `DTAC_ASSERT_IMPL(a_status_has_no_flags, r_out_valid && (r_kind == KIND_STATUS),
                      !r_mac_added && !r_ip_added)
    `DTAC_ASSERT_IMPL(a_addr_after_search, r_seq == SQ_ADDR,
                      !w_mac_sts.busy && !w_ip_sts.busy)
    `DTAC_ASSERT_IMPL(a_no_result_in_search, r_seq == SQ_SEARCH, !r_out_valid)

endmodule

`default_nettype wire
